### rtl/core/fat_chain_table_engine_top_macros.svh
// ----------------------------------------------------------------------------
// fat_chain_table_engine_top_macros
// assertion shorthands for the allocation table engine, clocked on i_clk and
// held off while i_rst_n is low
// ----------------------------------------------------------------------------
`ifndef FAT_CHAIN_TABLE_ENGINE_TOP_MACROS_SVH
`define FAT_CHAIN_TABLE_ENGINE_TOP_MACROS_SVH

// same-cycle implication
`define FCT_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FCT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/fct_pkg.sv
// ----------------------------------------------------------------------------
// fct_pkg
// shared types, codes and constants of the allocation table engine
// ----------------------------------------------------------------------------
package fct_pkg;

    // default table depth
    localparam int unsigned DEF_MAX_BLOCKS = 4096;

    // field widths
    localparam int unsigned OP_W       = 3;
    localparam int unsigned BLK_W      = 12;
    localparam int unsigned LINK_W     = 32;
    localparam int unsigned ST_W       = 2;
    localparam int unsigned CNT_W      = 13;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 13;

    // largest table size a 13-bit total can express
    localparam int unsigned CNT_MAX = 8191;

    // reserved link codes
    localparam logic [LINK_W-1:0] LINK_FREE = 32'h0000_0000;
    localparam logic [LINK_W-1:0] LINK_EOC  = 32'hFFFF_FFFF;

    // operation codes
    typedef enum logic [OP_W-1:0] {
        OP_FORMAT = 3'd0,
        OP_ALLOC  = 3'd1,
        OP_FREE   = 3'd2,
        OP_GET    = 3'd3,
        OP_SET    = 3'd4
    } t_op;

    // status codes
    localparam logic [ST_W-1:0] ST_OK     = 2'd0;
    localparam logic [ST_W-1:0] ST_RANGE  = 2'd1;
    localparam logic [ST_W-1:0] ST_NOFREE = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FAT_START = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FAT_CNT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_JRN_START = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_JRN_CNT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ROOT      = 3'd5;

    // regions marked by format, in marking order
    typedef enum logic [1:0] {
        RGN_BLK0 = 2'd0,
        RGN_FAT  = 2'd1,
        RGN_JRN  = 2'd2,
        RGN_ROOT = 2'd3
    } t_rgn;

    // configuration as seen by the sequencer
    typedef struct packed {
        logic [CNT_W-1:0] size;
        logic [BLK_W-1:0] fat_start;
        logic [CNT_W-1:0] fat_cnt;
        logic [BLK_W-1:0] jrn_start;
        logic [CNT_W-1:0] jrn_cnt;
        logic [BLK_W-1:0] root;
    } t_cfg;

    // table memory access
    typedef struct packed {
        logic              we;
        logic [LINK_W-1:0] addr;
        logic [LINK_W-1:0] wdata;
    } t_ram_req;

    // shared compare and count unit
    typedef struct packed {
        logic [LINK_W-1:0] ptr;
        logic [CNT_W-1:0]  size;
        logic [LINK_W-1:0] old_val;
        logic [LINK_W-1:0] new_val;
        logic [CNT_W-1:0]  free;
    } t_alu_in;

    typedef struct packed {
        logic              ptr_lt;
        logic [LINK_W-1:0] ptr_inc;
        logic [CNT_W-1:0]  free_nxt;
    } t_alu_out;

endpackage

### rtl/core/fct_req_if.sv
// ----------------------------------------------------------------------------
// fct_req_if
// request channel: operation, addressed entry and link to write
// ----------------------------------------------------------------------------
interface fct_req_if;
    logic                           valid;
    logic                           ready;
    logic [fct_pkg::OP_W-1:0]       op;
    logic [fct_pkg::BLK_W-1:0]      block_index;
    logic [fct_pkg::LINK_W-1:0]     link_value;

    modport source (output valid, output op, output block_index, output link_value,
                    input ready);
    modport sink   (input valid, input op, input block_index, input link_value,
                    output ready);
endinterface

### rtl/core/fct_rsp_if.sv
// ----------------------------------------------------------------------------
// fct_rsp_if
// response channel: status, returned value and free entry count
// ----------------------------------------------------------------------------
interface fct_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [fct_pkg::ST_W-1:0]       status;
    logic [fct_pkg::LINK_W-1:0]     value;
    logic [fct_pkg::CNT_W-1:0]      free_count;

    modport source (output valid, output status, output value, output free_count,
                    input ready);
    modport sink   (input valid, input status, input value, input free_count,
                    output ready);
endinterface

### rtl/core/fct_link_ram.sv
// ----------------------------------------------------------------------------
// fct_link_ram
// single-port link table, one access per cycle, registered read data
// ----------------------------------------------------------------------------
module fct_link_ram #(
    parameter int unsigned DEPTH = fct_pkg::DEF_MAX_BLOCKS
) (
    input  logic                       i_clk,
    input  fct_pkg::t_ram_req          i_ram,
    output logic [fct_pkg::LINK_W-1:0] o_rdata
);
    localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [fct_pkg::LINK_W-1:0] r_mem [DEPTH];
    logic [fct_pkg::LINK_W-1:0] r_rdata;
    logic [AddrW-1:0]           addr;

    assign addr    = i_ram.addr[AddrW-1:0];
    assign o_rdata = r_rdata;

    // write, or read when not writing
    always_ff @(posedge i_clk) begin
        if (i_ram.we) begin
            r_mem[addr] <= i_ram.wdata;
        end else begin
            r_rdata <= r_mem[addr];
        end
    end
endmodule

### rtl/core/fct_alu.sv
// ----------------------------------------------------------------------------
// fct_alu
// shared unit: pointer range compare, pointer increment and free count update
// ----------------------------------------------------------------------------
module fct_alu (
    input  fct_pkg::t_alu_in  i_alu,
    output fct_pkg::t_alu_out o_alu
);
    logic old_free;
    logic new_free;

    assign old_free = (i_alu.old_val == fct_pkg::LINK_FREE);
    assign new_free = (i_alu.new_val == fct_pkg::LINK_FREE);

    always_comb begin
        // pointer inside the table in use
        o_alu.ptr_lt  = i_alu.ptr < {{(fct_pkg::LINK_W - fct_pkg::CNT_W){1'b0}}, i_alu.size};
        o_alu.ptr_inc = i_alu.ptr + 32'd1;
        // free count follows an entry going in or out of the free state
        if (old_free && !new_free) begin
            o_alu.free_nxt = i_alu.free - 13'd1;
        end else if (!old_free && new_free) begin
            o_alu.free_nxt = i_alu.free + 13'd1;
        end else begin
            o_alu.free_nxt = i_alu.free;
        end
    end
endmodule

### rtl/core/fct_ctrl.sv
// ----------------------------------------------------------------------------
// fct_ctrl
// sequencer: clear sweep, format marking, allocate scan, chain walk,
// single link access, free recount and the response register
// ----------------------------------------------------------------------------
module fct_ctrl #(
    parameter int unsigned MAX_BLOCKS = fct_pkg::DEF_MAX_BLOCKS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  fct_pkg::t_cfg              i_cfg,
    input  logic                       i_size_wr,
    fct_req_if.sink                    i_req,
    fct_rsp_if.source                  o_rsp,
    output fct_pkg::t_ram_req          o_ram,
    input  logic [fct_pkg::LINK_W-1:0] i_ram_rdata,
    output fct_pkg::t_alu_in           o_alu,
    input  fct_pkg::t_alu_out          i_alu
);
    localparam logic [fct_pkg::LINK_W-1:0] LastIdx = fct_pkg::LINK_W'(MAX_BLOCKS - 1);

    typedef enum logic [14:0] {
        S_CLR  = 15'b000_0000_0000_0001,
        S_IDLE = 15'b000_0000_0000_0010,
        S_DISP = 15'b000_0000_0000_0100,
        S_FRG  = 15'b000_0000_0000_1000,
        S_FCK  = 15'b000_0000_0001_0000,
        S_FWR  = 15'b000_0000_0010_0000,
        S_ARD  = 15'b000_0000_0100_0000,
        S_ACK  = 15'b000_0000_1000_0000,
        S_WCHK = 15'b000_0001_0000_0000,
        S_WWR  = 15'b000_0010_0000_0000,
        S_GET  = 15'b000_0100_0000_0000,
        S_SET  = 15'b000_1000_0000_0000,
        S_CRD  = 15'b001_0000_0000_0000,
        S_CCK  = 15'b010_0000_0000_0000,
        S_DONE = 15'b100_0000_0000_0000
    } t_state;

    t_state                      r_state;
    logic [fct_pkg::LINK_W-1:0]  r_ptr;
    logic [fct_pkg::CNT_W-1:0]   r_cnt;
    fct_pkg::t_rgn               r_rgn;
    logic                        r_fmt;
    logic [fct_pkg::CNT_W-1:0]   r_free;
    logic [fct_pkg::OP_W-1:0]    r_op;
    logic [fct_pkg::LINK_W-1:0]  r_link;
    logic [fct_pkg::ST_W-1:0]    r_status;
    logic [fct_pkg::LINK_W-1:0]  r_value;
    logic                        r_out_vld;
    logic [fct_pkg::ST_W-1:0]    r_out_status;
    logic [fct_pkg::LINK_W-1:0]  r_out_value;
    logic [fct_pkg::CNT_W-1:0]   r_out_free;

    logic rd_zero;
    logic accept;
    logic load_out;

    assign rd_zero = (i_ram_rdata == fct_pkg::LINK_FREE);

    // request side: open only in idle and not on a size change
    assign i_req.ready = (r_state == S_IDLE) && !i_size_wr;
    assign accept      = i_req.valid && i_req.ready;

    // response register loads when a result is done and the register is free
    assign load_out = (r_state == S_DONE) && !i_size_wr && (!r_out_vld || o_rsp.ready);

    // response register
    assign o_rsp.valid      = r_out_vld;
    assign o_rsp.status     = r_out_status;
    assign o_rsp.value      = r_out_value;
    assign o_rsp.free_count = r_out_free;

    // shared unit operands
    always_comb begin
        o_alu.ptr     = r_ptr;
        o_alu.size    = i_cfg.size;
        o_alu.free    = r_free;
        // recount treats each read entry as a fresh write over a used one
        o_alu.old_val = (r_state == S_CCK) ? fct_pkg::LINK_EOC : i_ram_rdata;
        case (r_state)
            S_FWR, S_ACK: o_alu.new_val = fct_pkg::LINK_EOC;
            S_SET:        o_alu.new_val = r_link;
            S_CCK:        o_alu.new_val = i_ram_rdata;
            default:      o_alu.new_val = fct_pkg::LINK_FREE;
        endcase
    end

    // table access, always at the walk pointer
    always_comb begin
        o_ram.addr = r_ptr;
        o_ram.we   = (r_state == S_CLR) || (r_state == S_FWR) || (r_state == S_WWR) ||
                     (r_state == S_SET) || ((r_state == S_ACK) && rd_zero);
        case (r_state)
            S_FWR, S_ACK: o_ram.wdata = fct_pkg::LINK_EOC;
            S_SET:        o_ram.wdata = r_link;
            default:      o_ram.wdata = fct_pkg::LINK_FREE;
        endcase
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_ptr     <= '0;
            r_fmt     <= 1'b0;
            r_free    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            // response taken with nothing new to load
            if (r_out_vld && o_rsp.ready && !load_out) begin
                r_out_vld <= 1'b0;
            end

            if (i_size_wr && (r_state != S_CLR)) begin
                // new table size: count free entries again from zero
                r_ptr   <= '0;
                r_free  <= '0;
                r_state <= S_CRD;
            end else begin
                unique case (r_state)
                    // clear sweep over the whole memory
                    S_CLR: begin
                        if (r_ptr == LastIdx) begin
                            r_free  <= i_cfg.size;
                            r_rgn   <= fct_pkg::RGN_BLK0;
                            r_fmt   <= 1'b0;
                            r_state <= r_fmt ? S_FRG : S_IDLE;
                        end else begin
                            r_ptr <= i_alu.ptr_inc;
                        end
                    end
                    S_IDLE: begin
                        if (accept) begin
                            r_op     <= i_req.op;
                            r_link   <= i_req.link_value;
                            r_ptr    <= fct_pkg::LINK_W'(i_req.block_index);
                            r_status <= fct_pkg::ST_OK;
                            r_value  <= fct_pkg::LINK_FREE;
                            r_state  <= S_DISP;
                        end
                    end
                    // decode the request; get and set read the entry here
                    S_DISP: begin
                        unique case (r_op)
                            fct_pkg::OP_FORMAT: begin
                                r_ptr   <= '0;
                                r_fmt   <= 1'b1;
                                r_state <= S_CLR;
                            end
                            fct_pkg::OP_ALLOC: begin
                                r_ptr   <= 32'd1;
                                r_state <= S_ARD;
                            end
                            fct_pkg::OP_FREE: begin
                                if (i_alu.ptr_lt) begin
                                    r_state <= S_WCHK;
                                end else begin
                                    r_status <= fct_pkg::ST_RANGE;
                                    r_state  <= S_DONE;
                                end
                            end
                            fct_pkg::OP_GET: begin
                                if (i_alu.ptr_lt) begin
                                    r_state <= S_GET;
                                end else begin
                                    r_status <= fct_pkg::ST_RANGE;
                                    r_value  <= fct_pkg::LINK_EOC;
                                    r_state  <= S_DONE;
                                end
                            end
                            fct_pkg::OP_SET: begin
                                if (i_alu.ptr_lt) begin
                                    r_state <= S_SET;
                                end else begin
                                    r_status <= fct_pkg::ST_RANGE;
                                    r_state  <= S_DONE;
                                end
                            end
                            default: begin
                                r_state <= S_DONE;
                            end
                        endcase
                    end
                    // load the next reserved region
                    S_FRG: begin
                        unique case (r_rgn)
                            fct_pkg::RGN_BLK0: begin
                                r_ptr <= '0;
                                r_cnt <= 13'd1;
                            end
                            fct_pkg::RGN_FAT: begin
                                r_ptr <= fct_pkg::LINK_W'(i_cfg.fat_start);
                                r_cnt <= i_cfg.fat_cnt;
                            end
                            fct_pkg::RGN_JRN: begin
                                r_ptr <= fct_pkg::LINK_W'(i_cfg.jrn_start);
                                r_cnt <= i_cfg.jrn_cnt;
                            end
                            fct_pkg::RGN_ROOT: begin
                                r_ptr <= fct_pkg::LINK_W'(i_cfg.root);
                                r_cnt <= 13'd1;
                            end
                            default: begin
                                r_ptr <= '0;
                                r_cnt <= '0;
                            end
                        endcase
                        r_state <= S_FCK;
                    end
                    // region done once empty or past the table end
                    S_FCK: begin
                        if ((r_cnt == '0) || !i_alu.ptr_lt) begin
                            unique case (r_rgn)
                                fct_pkg::RGN_BLK0: r_rgn <= fct_pkg::RGN_FAT;
                                fct_pkg::RGN_FAT:  r_rgn <= fct_pkg::RGN_JRN;
                                fct_pkg::RGN_JRN:  r_rgn <= fct_pkg::RGN_ROOT;
                                default:           r_rgn <= fct_pkg::RGN_BLK0;
                            endcase
                            r_state <= (r_rgn == fct_pkg::RGN_ROOT) ? S_DONE : S_FRG;
                        end else begin
                            r_state <= S_FWR;
                        end
                    end
                    S_FWR: begin
                        r_free  <= i_alu.free_nxt;
                        r_ptr   <= i_alu.ptr_inc;
                        r_cnt   <= r_cnt - 13'd1;
                        r_state <= S_FCK;
                    end
                    // allocate scan from entry one
                    S_ARD: begin
                        if (!i_alu.ptr_lt) begin
                            r_status <= fct_pkg::ST_NOFREE;
                            r_state  <= S_DONE;
                        end else begin
                            r_state <= S_ACK;
                        end
                    end
                    S_ACK: begin
                        if (rd_zero) begin
                            r_free  <= i_alu.free_nxt;
                            r_value <= r_ptr;
                            r_state <= S_DONE;
                        end else begin
                            r_ptr   <= i_alu.ptr_inc;
                            r_state <= S_ARD;
                        end
                    end
                    // chain walk stops on a reserved code or a link off the table
                    S_WCHK: begin
                        if ((r_ptr == fct_pkg::LINK_FREE) || (r_ptr == fct_pkg::LINK_EOC) ||
                            !i_alu.ptr_lt) begin
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_WWR;
                        end
                    end
                    S_WWR: begin
                        r_free  <= i_alu.free_nxt;
                        r_ptr   <= i_ram_rdata;
                        r_state <= S_WCHK;
                    end
                    S_GET: begin
                        r_value <= i_ram_rdata;
                        r_state <= S_DONE;
                    end
                    S_SET: begin
                        r_free  <= i_alu.free_nxt;
                        r_state <= S_DONE;
                    end
                    // free recount over the table in use
                    S_CRD: begin
                        r_state <= i_alu.ptr_lt ? S_CCK : S_IDLE;
                    end
                    S_CCK: begin
                        r_free  <= i_alu.free_nxt;
                        r_ptr   <= i_alu.ptr_inc;
                        r_state <= S_CRD;
                    end
                    // hand the result over once the response register is free
                    S_DONE: begin
                        if (load_out) begin
                            r_out_vld    <= 1'b1;
                            r_out_status <= r_status;
                            r_out_value  <= r_value;
                            r_out_free   <= r_free;
                            r_state      <= S_IDLE;
                        end
                    end
                    default: begin
                        r_state <= S_IDLE;
                    end
                endcase
            end
        end
    end
endmodule

### rtl/core/fat_chain_table_engine_top.sv
// ----------------------------------------------------------------------------
// fat_chain_table_engine_top
// File allocation table engine holding MAX_BLOCKS 32-bit next-block links
// in one single-port memory, with free (zero) and end-of-chain (all ones)
// codes and a running free count reported with every response. After reset
// the block clears the memory, one entry a cycle, and takes no request
// meanwhile. One request is handled at a time by a sequencer around one
// compare and count unit, and in the scans, the chain walk and the recount
// each memory entry is handled as a read, then a write or check. Writing
// the table size register outside the clear sweep starts a recount of the
// free entries, during which no request is taken. The response waits in
// an output register; the next request can be taken while it is still
// pending.
// ----------------------------------------------------------------------------
`include "fat_chain_table_engine_top_macros.svh"

module fat_chain_table_engine_top #(
    parameter int unsigned MAX_BLOCKS = fct_pkg::DEF_MAX_BLOCKS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    fct_req_if.sink                         i_req,
    fct_rsp_if.source                       o_rsp,
    input  logic                            i_cfg_we,
    input  logic [fct_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [fct_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    localparam int unsigned LimitBlocks =
        (MAX_BLOCKS > fct_pkg::CNT_MAX) ? fct_pkg::CNT_MAX : MAX_BLOCKS;
    localparam logic [fct_pkg::CNT_W-1:0] SizeCap = fct_pkg::CNT_W'(LimitBlocks);

    logic [fct_pkg::CNT_W-1:0]  r_total;
    logic [fct_pkg::BLK_W-1:0]  r_fat_start;
    logic [fct_pkg::CNT_W-1:0]  r_fat_cnt;
    logic [fct_pkg::BLK_W-1:0]  r_jrn_start;
    logic [fct_pkg::CNT_W-1:0]  r_jrn_cnt;
    logic [fct_pkg::BLK_W-1:0]  r_root;

    logic [fct_pkg::CNT_W-1:0]  size;
    logic                       size_wr;
    fct_pkg::t_cfg              cfg;
    fct_pkg::t_ram_req          ram_req;
    logic [fct_pkg::LINK_W-1:0] ram_rdata;
    fct_pkg::t_alu_in           alu_in;
    fct_pkg::t_alu_out          alu_out;

    logic                       req_take;
    logic                       rsp_nofree;
    logic                       rsp_range;
    logic                       rsp_val_free;
    logic                       rsp_val_eoc;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total     <= 13'd4096;
            r_fat_start <= 12'd1;
            r_fat_cnt   <= 13'd1;
            r_jrn_start <= 12'd2;
            r_jrn_cnt   <= 13'd0;
            r_root      <= 12'd2;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                fct_pkg::CFG_TOTAL:     r_total     <= i_cfg_data;
                fct_pkg::CFG_FAT_START: r_fat_start <= i_cfg_data[fct_pkg::BLK_W-1:0];
                fct_pkg::CFG_FAT_CNT:   r_fat_cnt   <= i_cfg_data;
                fct_pkg::CFG_JRN_START: r_jrn_start <= i_cfg_data[fct_pkg::BLK_W-1:0];
                fct_pkg::CFG_JRN_CNT:   r_jrn_cnt   <= i_cfg_data;
                fct_pkg::CFG_ROOT:      r_root      <= i_cfg_data[fct_pkg::BLK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // table size in use is the smaller of the size register and the memory depth
    assign size    = (r_total > SizeCap) ? SizeCap : r_total;
    assign size_wr = i_cfg_we && (i_cfg_idx == fct_pkg::CFG_TOTAL);

    assign cfg.size      = size;
    assign cfg.fat_start = r_fat_start;
    assign cfg.fat_cnt   = r_fat_cnt;
    assign cfg.jrn_start = r_jrn_start;
    assign cfg.jrn_cnt   = r_jrn_cnt;
    assign cfg.root      = r_root;

    // sequencer
    fct_ctrl #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_size_wr   (size_wr),
        .i_req       (i_req),
        .o_rsp       (o_rsp),
        .o_ram       (ram_req),
        .i_ram_rdata (ram_rdata),
        .o_alu       (alu_in),
        .i_alu       (alu_out)
    );

    // shared compare and count unit
    fct_alu u_alu (
        .i_alu (alu_in),
        .o_alu (alu_out)
    );

    // link table
    fct_link_ram #(
        .DEPTH (MAX_BLOCKS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_ram   (ram_req),
        .o_rdata (ram_rdata)
    );

    // terms used by the checks
    assign req_take     = i_req.valid && i_req.ready;
    assign rsp_nofree   = o_rsp.valid && (o_rsp.status == fct_pkg::ST_NOFREE);
    assign rsp_range    = o_rsp.valid && (o_rsp.status == fct_pkg::ST_RANGE);
    assign rsp_val_free = (o_rsp.value == fct_pkg::LINK_FREE);
    assign rsp_val_eoc  = (o_rsp.value == fct_pkg::LINK_EOC);

    // checks
    `FCT_ASSERT_IMPL(a_free_bound, o_rsp.valid, o_rsp.free_count <= size, "free count above size")
    `FCT_ASSERT_IMPL(a_nofree_value, rsp_nofree, rsp_val_free, "failed allocate returned a block")
    `FCT_ASSERT_IMPL(a_range_value, rsp_range, rsp_val_free || rsp_val_eoc, "range error with a link")
    `FCT_ASSERT_NEXT(a_busy_after_req, req_take, !i_req.ready, "request taken while busy")

endmodule

### tb/fat_chain_table_engine_checker.sv
// ----------------------------------------------------------------------------
// fat_chain_table_engine_checker
// Watches the request, response and register ports of the allocation table
// engine. It keeps its own copy of the link table, free count and registers,
// works out the response of every accepted request, and compares each
// accepted response field by field with the oldest one still waiting.
// ----------------------------------------------------------------------------
module fat_chain_table_engine_checker #(
    parameter int unsigned MAX_BLOCKS = fct_pkg::DEF_MAX_BLOCKS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    fct_req_if                              i_req_mon,
    fct_rsp_if                              i_rsp_mon,
    input  logic                            i_cfg_we,
    input  logic [fct_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [fct_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output int                              o_fail_count,
    output int                              o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import fct_pkg::*;

    // one response as the engine should report it
    typedef struct packed {
        logic [ST_W-1:0]   status;
        logic [LINK_W-1:0] value;
        logic [CNT_W-1:0]  free_count;
    } t_table_rsp;

    // shadow of the engine state
    logic [LINK_W-1:0] link_mem [MAX_BLOCKS];
    int unsigned       free_total;
    t_cfg              cfg_q;
    t_table_rsp        rsp_expected [$];
    int                fail_total;

    // entries in use: the size register clipped to the table depth
    function automatic int unsigned live_size();
        return (cfg_q.size < MAX_BLOCKS) ? int'(cfg_q.size) : MAX_BLOCKS;
    endfunction

    function automatic void recount_free();
        int unsigned i;
        free_total = 0;
        for (i = 0; i < live_size(); i++) begin
            if (link_mem[i] == LINK_FREE) free_total++;
        end
    endfunction

    // write one entry inside the size and keep the free count current
    function automatic void put_link(int unsigned idx, logic [LINK_W-1:0] v);
        if (link_mem[idx] == LINK_FREE && v != LINK_FREE) free_total--;
        else if (link_mem[idx] != LINK_FREE && v == LINK_FREE) free_total++;
        link_mem[idx] = v;
    endfunction

    // end-of-chain over a span, skipping anything at or past the size
    function automatic void mark_span(int unsigned start, int unsigned count);
        int unsigned i;
        for (i = 0; i < count; i++) begin
            if (start + i < live_size()) put_link(start + i, LINK_EOC);
        end
    endfunction

    // carry out one request on the shadow table and return its response
    function automatic t_table_rsp apply_request(logic [OP_W-1:0] op,
                                                 logic [BLK_W-1:0] blk,
                                                 logic [LINK_W-1:0] link);
        int unsigned       n;
        int unsigned       i;
        logic [LINK_W-1:0] walk;
        logic [LINK_W-1:0] nxt;
        t_table_rsp        r;
        n = live_size();
        r.status = ST_OK;
        r.value  = '0;
        case (op)
            OP_FORMAT: begin
                foreach (link_mem[j]) link_mem[j] = LINK_FREE;
                free_total = n;
                mark_span(0, 1);
                mark_span(cfg_q.fat_start, cfg_q.fat_cnt);
                mark_span(cfg_q.jrn_start, cfg_q.jrn_cnt);
                mark_span(cfg_q.root, 1);
            end
            OP_ALLOC: begin
                // lowest free entry from index 1
                r.status = ST_NOFREE;
                for (i = 1; i < n; i++) begin
                    if (link_mem[i] == LINK_FREE) begin
                        put_link(i, LINK_EOC);
                        r.status = ST_OK;
                        r.value  = LINK_W'(i);
                        break;
                    end
                end
            end
            OP_FREE: begin
                if (blk >= n) begin
                    r.status = ST_RANGE;
                end else begin
                    // walk stops at free, end of chain or a link past the size
                    walk = LINK_W'(blk);
                    for (i = 0; i <= n; i++) begin
                        if (walk == LINK_FREE || walk == LINK_EOC || walk >= n) break;
                        nxt = link_mem[walk];
                        put_link(walk, LINK_FREE);
                        walk = nxt;
                    end
                end
            end
            OP_GET: begin
                if (blk < n) begin
                    r.value = link_mem[blk];
                end else begin
                    r.status = ST_RANGE;
                    r.value  = LINK_EOC;
                end
            end
            OP_SET: begin
                if (blk < n) put_link(blk, link);
                else r.status = ST_RANGE;
            end
            default: begin
                // unused codes leave everything alone
            end
        endcase
        r.free_count = (free_total > CNT_MAX) ? CNT_W'(CNT_MAX) : CNT_W'(free_total);
        return r;
    endfunction

    // register writes, response compare, request prediction
    always @(posedge i_clk) begin : table_monitor
        t_table_rsp want;
        if (!i_rst_n) begin
            foreach (link_mem[j]) link_mem[j] = LINK_FREE;
            cfg_q = '{size: CNT_W'(4096), fat_start: BLK_W'(1), fat_cnt: CNT_W'(1),
                      jrn_start: BLK_W'(2), jrn_cnt: CNT_W'(0), root: BLK_W'(2)};
            free_total = live_size();
            rsp_expected.delete();
            fail_total = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_TOTAL: begin
                        cfg_q.size = i_cfg_data;
                        recount_free();
                    end
                    CFG_FAT_START: cfg_q.fat_start = i_cfg_data[BLK_W-1:0];
                    CFG_FAT_CNT:   cfg_q.fat_cnt   = i_cfg_data;
                    CFG_JRN_START: cfg_q.jrn_start = i_cfg_data[BLK_W-1:0];
                    CFG_JRN_CNT:   cfg_q.jrn_cnt   = i_cfg_data;
                    CFG_ROOT:      cfg_q.root      = i_cfg_data[BLK_W-1:0];
                    default: ;
                endcase
            end

            if (i_rsp_mon.valid && i_rsp_mon.ready) begin
                if (rsp_expected.size() == 0) begin
                    $display("%0t response with none pending: status %0d value %h free %0d",
                             $time, i_rsp_mon.status, i_rsp_mon.value, i_rsp_mon.free_count);
                    fail_total++;
                end else begin
                    want = rsp_expected.pop_front();
                    if (i_rsp_mon.status !== want.status) begin
                        $display("%0t status mismatch: expected %0d actual %0d",
                                 $time, want.status, i_rsp_mon.status);
                        fail_total++;
                    end
                    if (i_rsp_mon.value !== want.value) begin
                        $display("%0t value mismatch: expected %h actual %h",
                                 $time, want.value, i_rsp_mon.value);
                        fail_total++;
                    end
                    if (i_rsp_mon.free_count !== want.free_count) begin
                        $display("%0t free count mismatch: expected %0d actual %0d",
                                 $time, want.free_count, i_rsp_mon.free_count);
                        fail_total++;
                    end
                end
            end

            if (i_req_mon.valid && i_req_mon.ready) begin
                rsp_expected.push_back(apply_request(i_req_mon.op, i_req_mon.block_index,
                                                     i_req_mon.link_value));
            end
        end
        o_pending    <= rsp_expected.size();
        o_fail_count <= fail_total;
    end

endmodule

### tb/fat_chain_table_engine_top_tb.sv
// ----------------------------------------------------------------------------
// fat_chain_table_engine_top_tb
// Drives the allocation table engine with a short directed run over reset
// values, a one-entry table and an empty table, then with register settings
// from the extremes to random small tables, each followed by random chains
// built with set next and torn down with free chain, allocations, reads,
// formats and random noise. Both handshake sides idle in random bursts, the
// response side holds off once for a long stretch, and the last phase runs
// without idling. The checker beside the engine does all the comparing.
// ----------------------------------------------------------------------------
module fat_chain_table_engine_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fct_pkg::*;

    localparam int unsigned TABLE_DEPTH  = DEF_MAX_BLOCKS;
    localparam int unsigned CYCLE_LIMIT  = 20_000_000;
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned DRAIN_CYCLES = 16;
    localparam int unsigned NUM_PHASES   = 9;
    localparam int unsigned PRESSURE_PH  = 3;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    fct_req_if req_ch ();
    fct_rsp_if rsp_ch ();

    int          fail_count;
    int          pending;
    int unsigned cycle_count = 0;
    int          rsp_stall   = 0;
    logic        quiet;
    logic        pressure_go;
    logic        holding;

    fat_chain_table_engine_top #(
        .MAX_BLOCKS (TABLE_DEPTH)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_ch),
        .o_rsp      (rsp_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    fat_chain_table_engine_checker #(
        .MAX_BLOCKS (TABLE_DEPTH)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_mon    (req_ch),
        .i_rsp_mon    (rsp_ch),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 10 ns clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // response side: random stall bursts, or the long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
            rsp_stall    <= 0;
        end else if (holding) begin
            rsp_ch.ready <= 1'b0;
        end else if (rsp_stall != 0) begin
            rsp_ch.ready <= 1'b0;
            rsp_stall    <= rsp_stall - 1;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            rsp_ch.ready <= 1'b0;
            rsp_stall    <= $urandom_range(0, 4);
        end else begin
            rsp_ch.ready <= 1'b1;
        end
    end

    // long hold-off on the response side so the engine backs up
    initial begin : rsp_hold_off
        holding <= 1'b0;
        @(posedge i_clk iff pressure_go);
        holding <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        holding <= 1'b0;
    end

    // offer one request, with an occasional gap first, and wait for acceptance
    task automatic send_request(input logic [OP_W-1:0]   op,
                                input logic [BLK_W-1:0]  blk,
                                input logic [LINK_W-1:0] link);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.op          <= op;
        req_ch.block_index <= blk;
        req_ch.link_value  <= link;
        @(posedge i_clk iff req_ch.ready);
    endtask

    // wait until every response is in, then let the engine settle
    task automatic drain_responses();
        req_ch.valid <= 1'b0;
        @(posedge i_clk iff pending == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // all six registers, table size last since it starts a recount
    task automatic program_setting(input t_cfg s);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_FAT_START;
        i_cfg_data <= CFG_DATA_W'(s.fat_start);
        @(posedge i_clk);
        i_cfg_idx  <= CFG_FAT_CNT;
        i_cfg_data <= s.fat_cnt;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_JRN_START;
        i_cfg_data <= CFG_DATA_W'(s.jrn_start);
        @(posedge i_clk);
        i_cfg_idx  <= CFG_JRN_CNT;
        i_cfg_data <= s.jrn_cnt;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_ROOT;
        i_cfg_data <= CFG_DATA_W'(s.root);
        @(posedge i_clk);
        i_cfg_idx  <= CFG_TOTAL;
        i_cfg_data <= s.size;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // mostly inside the table, sometimes anywhere in the 12-bit range
    function automatic logic [BLK_W-1:0] pick_index(input int unsigned n);
        if (n > 0 && $urandom_range(0, 9) < 8) return BLK_W'($urandom_range(0, n - 1));
        return BLK_W'($urandom_range(0, TABLE_DEPTH - 1));
    endfunction

    // chain tail: mostly end of chain, else free, past the size or raw
    function automatic logic [LINK_W-1:0] pick_tail_link(input int unsigned n);
        case ($urandom_range(0, 7))
            0: return LINK_FREE;
            1: return LINK_W'(n + $urandom_range(0, 3));
            2: return LINK_W'($urandom);
            default: return LINK_EOC;
        endcase
    endfunction

    // reset values, then a one-entry table, then an empty one
    task automatic run_directed();
        t_cfg s;
        send_request(OP_GET, BLK_W'(0), LINK_FREE);
        send_request(OP_GET, BLK_W'(4095), LINK_EOC);
        send_request(OP_ALLOC, BLK_W'(0), LINK_FREE);
        send_request(OP_FORMAT, BLK_W'(4095), LINK_EOC);
        send_request(OP_GET, BLK_W'(1), LINK_FREE);
        send_request(OP_ALLOC, BLK_W'(0), LINK_FREE);
        // chain ending in a link past the size, then freed
        send_request(OP_SET, BLK_W'(3), LINK_W'(5));
        send_request(OP_SET, BLK_W'(5), 32'h8000_0000);
        send_request(OP_FREE, BLK_W'(3), LINK_FREE);
        send_request(OP_SET, BLK_W'(4095), LINK_EOC);
        send_request(OP_GET, BLK_W'(4095), LINK_FREE);
        send_request(OP_SET, BLK_W'(4095), LINK_FREE);
        // chain start of zero frees nothing
        send_request(OP_FREE, BLK_W'(0), LINK_FREE);
        // unused op codes
        send_request(OP_W'(5), BLK_W'(4095), LINK_EOC);
        send_request(OP_W'(6), BLK_W'(1365), 32'h5555_5555);
        send_request(OP_W'(7), BLK_W'(0), LINK_FREE);
        drain_responses();

        // one-entry table with huge regions
        s = '{size: CNT_W'(1), fat_start: BLK_W'(0), fat_cnt: CNT_W'(4096),
              jrn_start: BLK_W'(4095), jrn_cnt: CNT_W'(4096), root: BLK_W'(4095)};
        program_setting(s);
        send_request(OP_ALLOC, BLK_W'(0), LINK_FREE);
        send_request(OP_GET, BLK_W'(1), LINK_FREE);
        send_request(OP_SET, BLK_W'(1), 32'hA5A5_A5A5);
        send_request(OP_FREE, BLK_W'(1), LINK_FREE);
        send_request(OP_FORMAT, BLK_W'(0), LINK_FREE);
        send_request(OP_GET, BLK_W'(0), LINK_FREE);
        drain_responses();

        // empty table: everything out of range
        s.size = CNT_W'(0);
        program_setting(s);
        send_request(OP_FORMAT, BLK_W'(0), LINK_FREE);
        send_request(OP_ALLOC, BLK_W'(0), LINK_FREE);
        send_request(OP_GET, BLK_W'(0), LINK_FREE);
        send_request(OP_FREE, BLK_W'(0), LINK_FREE);
        drain_responses();
    endtask

    // random requests; half of the draws start a chain build and teardown sequence
    task automatic run_random(input t_cfg s, input int unsigned count);
        int unsigned      n;
        int unsigned      sent;
        int unsigned      len;
        int unsigned      k;
        int unsigned      roll;
        logic [BLK_W-1:0] chain [6];
        n    = (s.size < TABLE_DEPTH) ? int'(s.size) : TABLE_DEPTH;
        sent = 0;
        while (sent < count) begin
            roll = $urandom_range(0, 99);
            if (roll < 50) begin
                len = $urandom_range(1, 6);
                for (k = 0; k < len; k++) chain[k] = pick_index(n);
                for (k = 0; k < len; k++) begin
                    send_request(OP_SET, chain[k],
                                 (k + 1 < len) ? LINK_W'(chain[k + 1]) : pick_tail_link(n));
                    sent++;
                end
                if ($urandom_range(0, 1) == 1) begin
                    send_request(OP_GET, chain[$urandom_range(0, len - 1)], LINK_W'($urandom));
                    sent++;
                end
                if ($urandom_range(0, 4) != 0) begin
                    send_request(OP_FREE, chain[0], LINK_W'($urandom));
                    sent++;
                end
            end else if (roll < 70) begin
                send_request(OP_ALLOC, BLK_W'($urandom), LINK_W'($urandom));
                sent++;
            end else if (roll < 82) begin
                send_request(OP_GET, pick_index(n), LINK_W'($urandom));
                sent++;
            end else if (roll < 84) begin
                send_request(OP_FORMAT, BLK_W'($urandom), LINK_W'($urandom));
                sent++;
            end else begin
                // noise: any op but format, raw fields
                send_request(OP_W'($urandom_range(1, 7)), BLK_W'($urandom), LINK_W'($urandom));
                sent++;
            end
        end
    endtask

    // reset, directed part, random phases, verdict
    initial begin : stimulus
        t_cfg        plan  [NUM_PHASES];
        int unsigned quota [NUM_PHASES];
        int unsigned sz;
        int unsigned ph;

        i_rst_n            <= 1'b0;
        i_cfg_we           <= 1'b0;
        i_cfg_idx          <= CFG_TOTAL;
        i_cfg_data         <= '0;
        req_ch.valid       <= 1'b0;
        req_ch.op          <= OP_FORMAT;
        req_ch.block_index <= '0;
        req_ch.link_value  <= '0;
        quiet              <= 1'b0;
        pressure_go        <= 1'b0;

        // highest values but a journal start of zero: format fills the whole table
        plan[0]  = '{size: CNT_W'(8191), fat_start: BLK_W'(4095), fat_cnt: CNT_W'(8191),
                     jrn_start: BLK_W'(0), jrn_cnt: CNT_W'(8191), root: BLK_W'(4095)};
        quota[0] = 40;
        // full depth, small regions
        plan[1]  = '{size: CNT_W'(4096), fat_start: BLK_W'(1), fat_cnt: CNT_W'(8),
                     jrn_start: BLK_W'(9), jrn_cnt: CNT_W'(16), root: BLK_W'(25)};
        quota[1] = 60;
        // lowest values: two entries, empty regions
        plan[2]  = '{size: CNT_W'(2), fat_start: BLK_W'(0), fat_cnt: CNT_W'(0),
                     jrn_start: BLK_W'(0), jrn_cnt: CNT_W'(0), root: BLK_W'(0)};
        quota[2] = 80;
        // small random tables, regions reaching past the end now and then
        for (ph = 3; ph < NUM_PHASES; ph++) begin
            sz        = $urandom_range(3, 64);
            plan[ph]  = '{size: CNT_W'(sz),
                          fat_start: BLK_W'($urandom_range(0, sz + 4)),
                          fat_cnt: CNT_W'($urandom_range(0, sz / 2)),
                          jrn_start: BLK_W'($urandom_range(0, sz + 4)),
                          jrn_cnt: CNT_W'($urandom_range(0, sz / 2)),
                          root: BLK_W'($urandom_range(0, sz + 2))};
            quota[ph] = 85;
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();

        for (ph = 0; ph < NUM_PHASES; ph++) begin
            if (ph == NUM_PHASES - 1) quiet <= 1'b1;
            program_setting(plan[ph]);
            if (ph == PRESSURE_PH) pressure_go <= 1'b1;
            run_random(plan[ph], quota[ph]);
            drain_responses();
        end

        if (fail_count == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

### files.f
+incdir+rtl/core
rtl/core/fct_pkg.sv
rtl/core/fct_req_if.sv
rtl/core/fct_rsp_if.sv
rtl/core/fct_link_ram.sv
rtl/core/fct_alu.sv
rtl/core/fct_ctrl.sv
rtl/core/fat_chain_table_engine_top.sv
tb/fat_chain_table_engine_checker.sv
tb/fat_chain_table_engine_top_tb.sv
